/* design/english_letter_frequency_score_macros.svh */
// ----------------------------------------------------------------------------
// English letter frequency score: assertion macros
// Shared concurrent assertion forms used by the scoring block.
// ----------------------------------------------------------------------------
`ifndef ENGLISH_LETTER_FREQUENCY_SCORE_MACROS_SVH
`define ENGLISH_LETTER_FREQUENCY_SCORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ELFS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// An antecedent that must be followed by a consequent in the next cycle.
`define ELFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* design/elfs_pkg.sv */
// ----------------------------------------------------------------------------
// English letter frequency score: package
// Widths, request types, character codes and the English frequency table.
// ----------------------------------------------------------------------------
package elfs_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BINS      = 256;
  localparam int unsigned ADDR_W    = $clog2(BINS);
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned LEN_W     = 17;
  localparam int unsigned SCORE_W   = 18;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned MAX_LEN   = 65536;
  localparam int unsigned SUM_W     = 42;
  localparam int unsigned FREQ_W    = FRAC_BITS;
  localparam int unsigned SHC_W     = CNT_W + FRAC_BITS;
  localparam int unsigned PROD_W    = FREQ_W + LEN_W;
  localparam int unsigned LETTERS   = 26;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LO_Z   = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_DIFF = 8'h20;

  localparam logic [23:0] ENG_FREQ24 [LETTERS] = '{
    24'd1342177, 24'd257698,  24'd432181,  24'd533348,  24'd2109903, 24'd588041,
    24'd332692,  24'd1046395, 24'd1160983, 24'd24327,   24'd124151,  24'd680652,
    24'd429665,  24'd1158299, 24'd1273558, 24'd301319,  24'd19797,   24'd999754,
    24'd1063843, 24'd1524210, 24'd476808,  24'd164752,  24'd373293,  24'd30199,
    24'd318935,  24'd13254
  };

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              last_byte;
  } in_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [LEN_W-1:0]   message_length;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  data;
  } hist_wr_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SCORE_W-1:0] quotient;
  } div_res_t;

  // Letter frequency rounded half up from 24 to FRAC_BITS fraction bits.
  function automatic logic [FREQ_W-1:0] freq_q(logic [4:0] idx);
    logic [24:0]   w;
    logic [FREQ_W:0] r;
    if (idx >= 5'(LETTERS)) begin
      return '0;
    end
    w = {ENG_FREQ24[idx], 1'b0} >> (24 - FRAC_BITS);
    r = w[FREQ_W:0] + (FREQ_W+1)'(1);
    return r[FREQ_W:1];
  endfunction

endpackage

/* design/elfs_hist.sv */
// ----------------------------------------------------------------------------
// English letter frequency score: histogram memory
// 256-bin count memory with one write port, one registered read port and
// forwarding of a write that lands on the entry read at the same edge.
// ----------------------------------------------------------------------------
module elfs_hist (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  elfs_pkg::hist_wr_t              wr_i,
  input  logic [elfs_pkg::ADDR_W-1:0]     rd_addr_i,
  output logic [elfs_pkg::CNT_W-1:0]      rd_data_o
);

  logic [elfs_pkg::CNT_W-1:0]  mem_q [elfs_pkg::BINS];
  logic [elfs_pkg::CNT_W-1:0]  rdata_q;
  logic [elfs_pkg::ADDR_W-1:0] raddr_q;
  logic                        fw_valid_q;
  logic [elfs_pkg::ADDR_W-1:0] fw_addr_q;
  logic [elfs_pkg::CNT_W-1:0]  fw_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q   <= mem_q[rd_addr_i];
    raddr_q   <= rd_addr_i;
    fw_addr_q <= wr_i.addr;
    fw_data_q <= wr_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_valid_q <= 1'b0;
    end else begin
      fw_valid_q <= wr_i.en;
    end
  end

  assign rd_data_o = (fw_valid_q && (fw_addr_q == raddr_q)) ? fw_data_q : rdata_q;

endmodule

/* design/elfs_div.sv */
// ----------------------------------------------------------------------------
// English letter frequency score: score divider
// Restoring divider, one quotient bit per cycle, with saturation of the
// quotient to the score width.
// ----------------------------------------------------------------------------
module elfs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  elfs_pkg::div_req_t req_i,
  output elfs_pkg::div_res_t res_o
);

  localparam int unsigned CNT_BITS = $clog2(elfs_pkg::SUM_W);

  logic                         busy_q;
  logic                         done_q;
  logic [CNT_BITS-1:0]          cnt_q;
  logic [elfs_pkg::SUM_W-1:0]   dvd_q;
  logic [elfs_pkg::LEN_W-1:0]   dvs_q;
  logic [elfs_pkg::LEN_W-1:0]   rem_q;
  logic [elfs_pkg::SCORE_W-1:0] quo_q;
  logic                         sat_q;
  logic [elfs_pkg::LEN_W:0]     rem_sh;
  logic [elfs_pkg::LEN_W:0]     rem_sub;
  logic                         ge;

  assign rem_sh  = {rem_q, dvd_q[elfs_pkg::SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(elfs_pkg::SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
      sat_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[elfs_pkg::SUM_W-2:0], 1'b0};
      rem_q <= ge ? rem_sub[elfs_pkg::LEN_W-1:0] : rem_sh[elfs_pkg::LEN_W-1:0];
      quo_q <= {quo_q[elfs_pkg::SCORE_W-2:0], ge};
      sat_q <= sat_q | quo_q[elfs_pkg::SCORE_W-1];
    end
  end

  assign res_o.done     = done_q;
  assign res_o.quotient = (dvs_q == '0) ? '0 : (sat_q ? elfs_pkg::SCORE_MAX : quo_q);

endmodule

/* design/english_letter_frequency_score.sv */
// ----------------------------------------------------------------------------
// English letter frequency score: top level
// Counts message bytes in a histogram memory and scores the message by its
// L1 distance from English letter frequencies.
// ----------------------------------------------------------------------------
// Input requests carry one message byte and a last flag over in_valid_i and
// in_stall_o; a request is taken at an edge with valid high and stall low.
// Bytes are taken one per cycle while the block collects a message; each
// byte is counted by a read-modify-write of the 256-entry histogram memory.
// Upper-case letters count as lower case. Bytes beyond 65536 are dropped and
// set the overflow bit of the result.
// After the last byte the block stalls its input, walks all 256 bins through
// the memory read port (clearing each bin behind it) and then divides the
// sum by the length one bit per cycle. The result request appears in the
// output register once the walk and the division are through. The next
// message is taken once the result sits in the output register, even while
// out_stall_i holds it.
// After reset the block clears all 256 bins of the histogram memory and
// holds in_stall_o high meanwhile. A stalled result holds its value.
// ----------------------------------------------------------------------------
`include "english_letter_frequency_score_macros.svh"

module english_letter_frequency_score (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  elfs_pkg::in_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output elfs_pkg::out_t out_req_o
);

  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_WALK = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [elfs_pkg::ADDR_W-1:0]  init_cnt_q;
  logic [elfs_pkg::ADDR_W:0]    walk_cnt_q;
  logic [elfs_pkg::LEN_W-1:0]   len_q;
  logic                         ovf_q;
  logic                         rinc_q;
  logic                         rwalk_q;
  logic [elfs_pkg::ADDR_W-1:0]  ra_q;
  logic                         pa_valid_q;
  logic                         pa_last_q;
  logic                         pa_letter_q;
  logic [elfs_pkg::CNT_W-1:0]   pa_cnt_q;
  logic [elfs_pkg::PROD_W-1:0]  pa_exp_q;
  logic [elfs_pkg::SUM_W-1:0]   sum_q;
  logic                         start_q;
  logic [elfs_pkg::SCORE_W-1:0] score_q;
  logic                         out_valid_q;
  elfs_pkg::out_t               out_q;

  logic                         accept;
  logic                         counted;
  logic [elfs_pkg::BYTE_W-1:0]  folded;
  logic [elfs_pkg::ADDR_W-1:0]  rd_addr;
  logic [elfs_pkg::CNT_W-1:0]   rd_data;
  elfs_pkg::hist_wr_t           wr;
  elfs_pkg::div_req_t           div_req;
  elfs_pkg::div_res_t           div_res;
  logic [elfs_pkg::FREQ_W-1:0]  freq;
  logic [elfs_pkg::SHC_W-1:0]   cnt_sh;
  logic [elfs_pkg::SHC_W-1:0]   bin_dist;
  logic                         slot_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign counted    = len_q < elfs_pkg::LEN_W'(elfs_pkg::MAX_LEN);
  assign slot_free  = !out_valid_q || !out_stall_i;

  assign folded = (in_req_i.byte_value inside {[elfs_pkg::CH_UP_A:elfs_pkg::CH_UP_Z]})
                ? in_req_i.byte_value + elfs_pkg::CASE_DIFF : in_req_i.byte_value;

  assign rd_addr = (state_q == ST_WALK) ? walk_cnt_q[elfs_pkg::ADDR_W-1:0] : folded;

  always_comb begin
    wr = '0;
    if (state_q == ST_INIT) begin
      wr.en   = 1'b1;
      wr.addr = init_cnt_q;
    end else if (rinc_q) begin
      wr.en   = 1'b1;
      wr.addr = ra_q;
      wr.data = rd_data + elfs_pkg::CNT_W'(1);
    end else if (rwalk_q) begin
      wr.en   = 1'b1;
      wr.addr = ra_q;
    end
  end

  elfs_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign freq   = elfs_pkg::freq_q(5'(ra_q - elfs_pkg::CH_LO_A));
  assign cnt_sh = {pa_cnt_q, elfs_pkg::FRAC_BITS'(0)};
  always_comb begin
    if (!pa_letter_q) begin
      bin_dist = cnt_sh;
    end else if (cnt_sh >= pa_exp_q) begin
      bin_dist = cnt_sh - pa_exp_q;
    end else begin
      bin_dist = pa_exp_q - cnt_sh;
    end
  end

  assign div_req.start    = start_q;
  assign div_req.dividend = sum_q;
  assign div_req.divisor  = len_q;

  elfs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (init_cnt_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && in_req_i.last_byte) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (start_q) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_res.done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_cnt_q  <= '0;
      walk_cnt_q  <= '0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      rinc_q      <= 1'b0;
      rwalk_q     <= 1'b0;
      pa_valid_q  <= 1'b0;
      pa_last_q   <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INIT) begin
        init_cnt_q <= init_cnt_q + elfs_pkg::ADDR_W'(1);
      end
      rinc_q <= accept && counted;
      if (accept) begin
        if (counted) begin
          len_q <= len_q + elfs_pkg::LEN_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (accept && in_req_i.last_byte) begin
        walk_cnt_q <= '0;
      end else if (state_q == ST_WALK && !walk_cnt_q[elfs_pkg::ADDR_W]) begin
        walk_cnt_q <= walk_cnt_q + (elfs_pkg::ADDR_W+1)'(1);
      end
      rwalk_q    <= (state_q == ST_WALK) && !walk_cnt_q[elfs_pkg::ADDR_W];
      pa_valid_q <= rwalk_q;
      pa_last_q  <= rwalk_q && (ra_q == '1);
      start_q    <= pa_valid_q && pa_last_q;
      if (state_q == ST_OUT && slot_free) begin
        out_valid_q <= 1'b1;
        len_q       <= '0;
        ovf_q       <= 1'b0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WALK) begin
      ra_q <= walk_cnt_q[elfs_pkg::ADDR_W-1:0];
    end else begin
      ra_q <= folded;
    end
    pa_cnt_q    <= rd_data;
    pa_letter_q <= ra_q inside {[elfs_pkg::CH_LO_A:elfs_pkg::CH_LO_Z]};
    pa_exp_q    <= freq * len_q;
    if (accept && in_req_i.last_byte) begin
      sum_q <= '0;
    end else if (pa_valid_q) begin
      sum_q <= sum_q + elfs_pkg::SUM_W'(bin_dist);
    end
    if (div_res.done) begin
      score_q <= div_res.quotient;
    end
    if (state_q == ST_OUT && slot_free) begin
      out_q.score          <= score_q;
      out_q.message_length <= len_q;
      out_q.overflow       <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `ELFS_ASSERT(a_one_writer, clk_i, rst_ni, !(rinc_q && rwalk_q), "Increment and walk write collide.")
  `ELFS_ASSERT(a_len_bound, clk_i, rst_ni, len_q <= elfs_pkg::LEN_W'(elfs_pkg::MAX_LEN), "Length count exceeds its limit.")
  `ELFS_ASSERT_NEXT(a_out_load, clk_i, rst_ni, !out_valid_q && (state_q != ST_OUT), !out_valid_q, "Result appeared without a finished score.")

endmodule
